// ===== rtl/core/gks_pkg.sv =====
// shared types, field widths and codes for the grid kernel scatter accumulator
// no dependencies; every other file of the block but gks_ram imports this package
package gks_pkg;

    // default geometry limits
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_REACH_DEF  = 4;

    // request and result field widths
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 13;
    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int SAMPLE_W = 17;
    localparam int WEIGHT_W = 25;
    localparam int ACC_W    = 32;
    localparam int STATUS_W = 2;

    // configuration register widths and apb geometry
    localparam int GEO_W      = 7;
    localparam int REACH_W    = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // fixed point: q1.16 times q1.24 gives q2.40, drop 12 bits for q2.28, added into q4.28
    localparam int PROD_SHIFT = 12;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W - PROD_SHIFT;

    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(16777216);

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_PRESET  = 2'd1,
        ACT_SCATTER = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_RANGE = 2'd1,
        STS_SAT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_REACH  = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    // strobes from the sequencer to the memories, the mac unit and the result register
    typedef struct packed {
        logic clr_wr;
        logic preset_wr;
        logic acc_rd;
        logic kern_wr;
        logic kern_rd;
        logic mac_issue;
        logic result_load;
        logic result_read;
    } seq_ctrl_t;

    // multiply-accumulate unit status back to the sequencer
    typedef struct packed {
        logic busy;
        logic sat;
    } mac_stat_t;

endpackage

// ===== rtl/core/gks_if.sv =====
// request and result channel interfaces with valid/ready handshake
// depends on gks_pkg for the field widths
interface gks_in_if import gks_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [ROW_W-1:0]    grid_row;
    logic [COL_W-1:0]    grid_col;
    logic [SAMPLE_W-1:0] sample;
    logic [WEIGHT_W-1:0] weight;
    logic [ACC_W-1:0]    preset_value;

    modport source (
        output valid, action, address, grid_row, grid_col, sample, weight, preset_value,
        input  ready
    );
    modport sink (
        input  valid, action, address, grid_row, grid_col, sample, weight, preset_value,
        output ready
    );
endinterface

interface gks_out_if import gks_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACC_W-1:0]    read_value;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, read_value, status,
        input  ready
    );
    modport sink (
        input  valid, read_value, status,
        output ready
    );
endinterface

// ===== rtl/core/gks_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module gks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/gks_mac.sv =====
// shared multiply-accumulate unit: sample times weight, truncate, saturating add
// depends on gks_pkg; fed by the accumulator and kernel rams
module gks_mac import gks_pkg::*; #(
    parameter int AA_W = 13
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                issue,
    input  logic [AA_W-1:0]     issue_addr,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [ACC_W-1:0]    acc_rdata,
    output logic                wr_en,
    output logic [AA_W-1:0]     wr_addr,
    output logic [ACC_W-1:0]    wr_data,
    output mac_stat_t           stat
);

    logic                         v1_reg;
    logic                         v2_reg;
    logic [AA_W-1:0]              addr1_reg;
    logic [AA_W-1:0]              addr2_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [ACC_W-1:0]             acc_reg;
    logic [SAMPLE_W+WEIGHT_W-1:0] prod_full;
    logic [ACC_W:0]               sum;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    // product of the sample and the weight read for this cell
    assign prod_full = sample * weight;

    // stage 1 lines up with the ram read data, stage 2 holds the product
    always_ff @(posedge clk)
    begin
        addr1_reg <= issue_addr;
        addr2_reg <= addr1_reg;
        prod_reg  <= prod_full[SAMPLE_W+WEIGHT_W-1:PROD_SHIFT];
        acc_reg   <= acc_rdata;
    end

    // saturating add and write back
    assign sum      = {1'b0, acc_reg} + (ACC_W+1)'(prod_reg);
    assign stat.sat = v2_reg & sum[ACC_W];
    assign stat.busy = v1_reg | v2_reg;
    assign wr_en    = v2_reg;
    assign wr_addr  = addr2_reg;
    assign wr_data  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

    a_wr_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> $past(issue, 2))
        else $error("write back without a matching issue");

    a_wr_addr_kept: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> wr_addr == $past(issue_addr, 2))
        else $error("write back address lost in the pipeline");

    a_busy_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        issue |=> stat.busy)
        else $error("unit not busy after an issue");

endmodule

// ===== rtl/core/gks_seq.sv =====
// sequencer: clearing pass, request decode, kernel sweep and result hand-off
// depends on gks_pkg; drives the rams and the shared mac unit
module gks_seq import gks_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_REACH  = MAX_REACH_DEF,
    localparam int ACC_DEPTH  = (MAX_WIDTH + 2 * MAX_REACH) * (MAX_HEIGHT + 2 * MAX_REACH),
    localparam int KERN_DEPTH = (2 * MAX_REACH + 1) * (2 * MAX_REACH + 1),
    localparam int AA_W    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1,
    localparam int KA_W    = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1,
    localparam int KC_W    = $clog2(KERN_DEPTH + 1),
    localparam int R_W     = (MAX_REACH > 0) ? $clog2(MAX_REACH + 1) : 1,
    localparam int S_W     = R_W + 1,
    localparam int W_W     = $clog2(MAX_WIDTH + 1),
    localparam int H_W     = $clog2(MAX_HEIGHT + 1),
    localparam int PW_W    = $clog2(MAX_WIDTH + 2 * MAX_REACH + 1),
    localparam int CELLS_W = $clog2(ACC_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [ADDR_W-1:0]   address,
    input  logic [ROW_W-1:0]    grid_row,
    input  logic [COL_W-1:0]    grid_col,
    input  logic [W_W-1:0]      w_eff,
    input  logic [H_W-1:0]      h_eff,
    input  logic [S_W-1:0]      side,
    input  logic [KC_W-1:0]     side_sq,
    input  logic [PW_W-1:0]     pw,
    input  logic [CELLS_W-1:0]  cells,
    input  logic                out_free,
    input  mac_stat_t           mac_stat,
    output seq_ctrl_t           ctrl,
    output logic [AA_W-1:0]     acc_addr,
    output logic [KA_W-1:0]     kern_addr,
    output status_t             status
);

    seq_state_t        state_reg, state_next;
    action_t           act_reg, act_next;
    logic [ADDR_W-1:0] addr_in_reg, addr_in_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [AA_W-1:0]   acc_ptr_reg, acc_ptr_next;
    logic [AA_W-1:0]   row_base_reg, row_base_next;
    logic [S_W-1:0]    dj_reg, dj_next;
    logic [KC_W-1:0]   k_reg, k_next;
    logic [AA_W-1:0]   clr_reg, clr_next;
    status_t           status_reg, status_next;

    logic            scat_ok;
    logic            kern_ok;
    logic            cell_ok;
    logic            row_end;
    logic            last_cell;
    logic            clr_last;
    logic [AA_W-1:0] base;

    // decode of the held request against the current geometry
    assign scat_ok   = (row_reg < h_eff) && (col_reg < w_eff);
    assign kern_ok   = addr_in_reg < side_sq;
    assign cell_ok   = addr_in_reg < cells;
    assign row_end   = S_W'(dj_reg + 1'b1) == side;
    assign last_cell = KC_W'(k_reg + 1'b1) == side_sq;
    assign clr_last  = clr_reg == AA_W'(ACC_DEPTH - 1);
    assign base      = AA_W'(AA_W'(row_reg) * AA_W'(pw)) + AA_W'(col_reg);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            status_reg <= STS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            status_reg <= status_next;
        end
    end

    // request and sweep registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        addr_in_reg  <= addr_in_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        acc_ptr_reg  <= acc_ptr_next;
        row_base_reg <= row_base_next;
        dj_reg       <= dj_next;
        k_reg        <= k_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (act_reg == ACT_SCATTER && scat_ok)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN:
            begin
                if (last_cell)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // counters, pointers and held request
    always_comb
    begin
        act_next      = act_reg;
        addr_in_next  = addr_in_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        acc_ptr_next  = acc_ptr_reg;
        row_base_next = row_base_reg;
        dj_next       = dj_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        status_next   = status_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = AA_W'(clr_reg + 1'b1);
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = action_t'(action);
                    addr_in_next = address;
                    row_next     = grid_row;
                    col_next     = grid_col;
                    status_next  = STS_OK;
                end
            end
            ST_EXEC:
            begin
                unique case (act_reg)
                    ACT_LOAD:
                    begin
                        status_next = kern_ok ? STS_OK : STS_RANGE;
                    end
                    ACT_PRESET, ACT_READ:
                    begin
                        status_next = cell_ok ? STS_OK : STS_RANGE;
                    end
                    ACT_SCATTER:
                    begin
                        status_next   = scat_ok ? STS_OK : STS_RANGE;
                        acc_ptr_next  = base;
                        row_base_next = base;
                        dj_next       = '0;
                        k_next        = '0;
                    end
                    default:
                    begin
                        status_next = STS_RANGE;
                    end
                endcase
            end
            ST_RUN:
            begin
                k_next = KC_W'(k_reg + 1'b1);
                if (row_end)
                begin
                    // step to the first cell of the next padded row
                    row_base_next = AA_W'(row_base_reg + AA_W'(pw));
                    acc_ptr_next  = AA_W'(row_base_reg + AA_W'(pw));
                    dj_next       = '0;
                end
                else
                begin
                    acc_ptr_next = AA_W'(acc_ptr_reg + 1'b1);
                    dj_next      = S_W'(dj_reg + 1'b1);
                end
                if (mac_stat.sat)
                begin
                    status_next = STS_SAT;
                end
            end
            ST_DRAIN:
            begin
                if (mac_stat.sat)
                begin
                    status_next = STS_SAT;
                end
            end
            ST_DONE:
            begin
                status_next = status_reg;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // strobes and addresses
    always_comb
    begin
        ctrl      = '0;
        in_ready  = 1'b0;
        acc_addr  = acc_ptr_reg;
        kern_addr = k_reg[KA_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clr_wr = 1'b1;
                acc_addr    = clr_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                acc_addr       = AA_W'(addr_in_reg);
                kern_addr      = KA_W'(addr_in_reg);
                ctrl.kern_wr   = (act_reg == ACT_LOAD) && kern_ok;
                ctrl.preset_wr = (act_reg == ACT_PRESET) && cell_ok;
                ctrl.acc_rd    = (act_reg == ACT_READ) && cell_ok;
            end
            ST_RUN:
            begin
                ctrl.acc_rd    = 1'b1;
                ctrl.kern_rd   = 1'b1;
                ctrl.mac_issue = 1'b1;
            end
            ST_DRAIN:
            begin
                ctrl = '0;
            end
            ST_DONE:
            begin
                ctrl.result_load = out_free;
                ctrl.result_read = (act_reg == ACT_READ) && (status_reg == STS_OK);
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign status = status_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.result_load |-> out_free)
        else $error("result loaded over a waiting result");

    a_sweep_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> acc_ptr_reg < cells)
        else $error("scatter sweep left the padded store");

    a_sat_only_scatter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && status_reg == STS_SAT) |-> act_reg == ACT_SCATTER)
        else $error("saturation reported for a non-scatter request");

    a_done_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> !mac_stat.busy)
        else $error("result handed off while write back still pending");

endmodule

// ===== rtl/core/grid_kernel_scatter_accumulate_top.sv =====
// top level of the grid kernel scatter accumulator: apb registers, rams, result register
// depends on gks_pkg, gks_if, gks_ram, gks_mac and gks_seq
//
//  channel  dir  handshake       carries
//  in_ch    in   valid/ready     action, address, grid_row, grid_col, sample, weight,
//                                preset_value
//  out_ch   out  valid/ready     read_value, status
//  apb      in   psel/penable    grid_width, grid_height, reach at byte 0, 4, 8
//
// load, preset and read hold the block through its accept, execute and hand-off states;
// a scatter adds a kernel sweep with one read-modify-write a cycle on the accumulator ram,
// then waits in a drain state until the mac pipeline is empty.
// after reset a clearing pass writes zero to all (MAX_WIDTH+2*MAX_REACH)*
// (MAX_HEIGHT+2*MAX_REACH) cells (5184 by default) with in_ch.ready low.
// one request is in work at a time; the result register waits on out_ch.ready and
// the next request is taken in the cycle after the result has been loaded into it.
module grid_kernel_scatter_accumulate_top import gks_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_REACH  = MAX_REACH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gks_in_if.sink                in_ch,
    gks_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ACC_DEPTH  = (MAX_WIDTH + 2 * MAX_REACH) * (MAX_HEIGHT + 2 * MAX_REACH);
    localparam int KERN_DEPTH = (2 * MAX_REACH + 1) * (2 * MAX_REACH + 1);
    localparam int AA_W    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int KA_W    = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
    localparam int KC_W    = $clog2(KERN_DEPTH + 1);
    localparam int R_W     = (MAX_REACH > 0) ? $clog2(MAX_REACH + 1) : 1;
    localparam int S_W     = R_W + 1;
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int PW_W    = $clog2(MAX_WIDTH + 2 * MAX_REACH + 1);
    localparam int PH_W    = $clog2(MAX_HEIGHT + 2 * MAX_REACH + 1);
    localparam int CELLS_W = $clog2(ACC_DEPTH + 1);

    logic [GEO_W-1:0]   grid_width_reg;
    logic [GEO_W-1:0]   grid_height_reg;
    logic [REACH_W-1:0] reach_reg;
    logic               cfg_wr;

    logic [W_W-1:0]     w_eff;
    logic [H_W-1:0]     h_eff;
    logic [R_W-1:0]     r_eff;
    logic [S_W-1:0]     side;
    logic [KC_W-1:0]    side_sq;
    logic [PW_W-1:0]    pw;
    logic [PH_W-1:0]    ph;
    logic [CELLS_W-1:0] cells;

    logic                in_fire;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [ACC_W-1:0]    preset_reg;

    seq_ctrl_t       ctrl;
    mac_stat_t       mac_stat;
    status_t         seq_status;
    logic [AA_W-1:0] acc_addr;
    logic [KA_W-1:0] kern_addr;

    logic [KERN_DEPTH-1:0] kv_reg;
    logic                  kv_rd_reg;
    logic [WEIGHT_W-1:0]   kern_rdata;
    logic [WEIGHT_W-1:0]   weight_eff;

    logic             acc_we;
    logic [AA_W-1:0]  acc_waddr;
    logic [ACC_W-1:0] acc_wdata;
    logic [ACC_W-1:0] acc_rdata;
    logic             mac_we;
    logic [AA_W-1:0]  mac_waddr;
    logic [ACC_W-1:0] mac_wdata;

    logic                out_valid_reg;
    logic [ACC_W-1:0]    read_value_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic                out_free;

    // apb configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GEO_W'(64);
            grid_height_reg <= GEO_W'(64);
            reach_reg       <= REACH_W'(4);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_WIDTH:  grid_width_reg  <= pwdata[GEO_W-1:0];
                REG_HEIGHT: grid_height_reg <= pwdata[GEO_W-1:0];
                REG_REACH:  reach_reg       <= pwdata[REACH_W-1:0];
                default:    grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            REG_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            REG_REACH:  prdata = APB_DATA_W'(reach_reg);
            default:    prdata = '0;
        endcase
    end

    // effective geometry, registers clamped to their usable range
    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            w_eff = W_W'(1);
        end
        else if (int'(grid_width_reg) > MAX_WIDTH)
        begin
            w_eff = W_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = W_W'(grid_width_reg);
        end
        if (grid_height_reg == '0)
        begin
            h_eff = H_W'(1);
        end
        else if (int'(grid_height_reg) > MAX_HEIGHT)
        begin
            h_eff = H_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = H_W'(grid_height_reg);
        end
        if (int'(reach_reg) > MAX_REACH)
        begin
            r_eff = R_W'(MAX_REACH);
        end
        else
        begin
            r_eff = R_W'(reach_reg);
        end
    end

    assign side    = {r_eff, 1'b1};
    assign side_sq = KC_W'(KC_W'(side) * KC_W'(side));
    assign pw      = PW_W'(w_eff) + PW_W'({r_eff, 1'b0});
    assign ph      = PH_W'(h_eff) + PH_W'({r_eff, 1'b0});
    assign cells   = CELLS_W'(CELLS_W'(pw) * CELLS_W'(ph));

    // request payload; sample and weight clamped to one on the way in
    assign in_fire = in_ch.valid & in_ch.ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= (in_ch.sample > SAMPLE_ONE) ? SAMPLE_ONE : in_ch.sample;
            weight_reg <= (in_ch.weight > WEIGHT_ONE) ? WEIGHT_ONE : in_ch.weight;
            preset_reg <= in_ch.preset_value;
        end
    end

    gks_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_REACH  (MAX_REACH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .action    (in_ch.action),
        .address   (in_ch.address),
        .grid_row  (in_ch.grid_row),
        .grid_col  (in_ch.grid_col),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .side      (side),
        .side_sq   (side_sq),
        .pw        (pw),
        .cells     (cells),
        .out_free  (out_free),
        .mac_stat  (mac_stat),
        .ctrl      (ctrl),
        .acc_addr  (acc_addr),
        .kern_addr (kern_addr),
        .status    (seq_status)
    );

    // kernel weights: ram plus a written flag per entry, unwritten reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kv_reg    <= '0;
            kv_rd_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.kern_wr)
            begin
                kv_reg[kern_addr] <= 1'b1;
            end
            if (ctrl.kern_rd)
            begin
                kv_rd_reg <= kv_reg[kern_addr];
            end
        end
    end

    gks_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (KERN_DEPTH),
        .AW    (KA_W)
    ) u_kern_ram (
        .clk     (clk),
        .wr_en   (ctrl.kern_wr),
        .wr_addr (kern_addr),
        .wr_data (weight_reg),
        .rd_en   (ctrl.kern_rd),
        .rd_addr (kern_addr),
        .rd_data (kern_rdata)
    );

    assign weight_eff = kv_rd_reg ? kern_rdata : '0;

    gks_mac #(
        .AA_W (AA_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .issue      (ctrl.mac_issue),
        .issue_addr (acc_addr),
        .sample     (sample_reg),
        .weight     (weight_eff),
        .acc_rdata  (acc_rdata),
        .wr_en      (mac_we),
        .wr_addr    (mac_waddr),
        .wr_data    (mac_wdata),
        .stat       (mac_stat)
    );

    // accumulator write port: clearing pass, preset or mac write back
    always_comb
    begin
        acc_waddr = acc_addr;
        acc_wdata = '0;
        priority if (ctrl.clr_wr)
        begin
            acc_wdata = '0;
        end
        else if (mac_we)
        begin
            acc_waddr = mac_waddr;
            acc_wdata = mac_wdata;
        end
        else
        begin
            acc_wdata = preset_reg;
        end
    end

    assign acc_we = ctrl.clr_wr | ctrl.preset_wr | mac_we;

    gks_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH),
        .AW    (AA_W)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (acc_we),
        .wr_addr (acc_waddr),
        .wr_data (acc_wdata),
        .rd_en   (ctrl.acc_rd),
        .rd_addr (acc_addr),
        .rd_data (acc_rdata)
    );

    // result register
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.result_load)
        begin
            read_value_reg <= ctrl.result_read ? acc_rdata : '0;
            status_out_reg <= seq_status;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.read_value = read_value_reg;
    assign out_ch.status     = status_out_reg;

endmodule
